/* src/lpht_pkg.sv */
// Package for the linear probing hash table: payload types, codes, FNV constants.
// Used by every module in src. No dependencies.
package lpht_pkg;

    localparam int TableDepth = 256;
    localparam int SlotBits   = $clog2(TableDepth);
    localparam int CountBits  = 9;
    localparam int ValueBits  = 32;
    localparam int KeyBits    = 64;
    localparam int QueueDepth = 2;

    localparam logic [31:0] FnvBasis = 32'd2166136261;
    localparam logic [31:0] FnvMult  = 32'd16777619;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_GET    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2,
        MARK_UNUSED = 2'd3
    } t_mark;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic        status;
        logic [31:0] value_out;
        logic [8:0]  occupancy;
    } t_out_beat;

    // Work handed from the front (hash) to the back (probe).
    typedef struct packed {
        t_action             action;
        logic [KeyBits-1:0]  key_masked;
        logic [KeyBits-1:0]  key_mask;
        logic [ValueBits-1:0] value;
        logic [SlotBits-1:0] home;
    } t_job;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_HASH,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_CHECK,
        BS_DONE,
        BS_CLEAR
    } t_back_state;

endpackage

/* src/lpht_front.sv */
// Front part: accepts input beats, clamps key width, hashes with FNV-1a a byte a cycle.
// Depends on lpht_pkg.
module lpht_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lpht_pkg::t_in_beat i_beat,
    input  logic [3:0]         i_key_bytes,
    output logic               o_push,
    output lpht_pkg::t_job     o_job,
    input  logic               i_full
);
    import lpht_pkg::*;

    t_front_state r_state, n_state;
    t_in_beat     r_beat;
    logic [3:0]   r_nbytes;
    logic [2:0]   r_idx;
    logic [31:0]  r_hash, n_hash;
    logic [3:0]   w_eff;
    logic [63:0]  w_mask;
    logic [7:0]   w_byte;

    always_comb begin
        if (i_key_bytes == 4'd0) begin
            w_eff = 4'd1;
        end else if (i_key_bytes > 4'd8) begin
            w_eff = 4'd8;
        end else begin
            w_eff = i_key_bytes;
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[b*8 +: 8] = (4'(b) < r_nbytes) ? 8'hFF : 8'h00;
        end
    end

    assign w_byte = r_beat.key[{r_idx, 3'b000} +: 8];
    assign n_hash = (r_hash ^ {24'd0, w_byte}) * FnvMult;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_valid) begin
            r_beat   <= i_beat;
            r_nbytes <= w_eff;
            r_idx    <= 3'd0;
            r_hash   <= FnvBasis;
        end else if (r_state == FS_HASH) begin
            r_hash <= n_hash;
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_push  = 1'b0;
        unique case (r_state)
            FS_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = FS_HASH;
                end
            end
            FS_HASH: begin
                if ({1'b0, r_idx} + 4'd1 == r_nbytes) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    assign o_job.action     = t_action'(r_beat.action);
    assign o_job.key_mask   = w_mask;
    assign o_job.key_masked = r_beat.key & w_mask;
    assign o_job.value      = r_beat.value;
    assign o_job.home       = r_hash[SlotBits-1:0];

endmodule

/* src/lpht_queue.sv */
// Short job queue between the hash front and the probe back.
// Depends on lpht_pkg.
module lpht_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpht_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output lpht_pkg::t_job  o_job
);
    import lpht_pkg::*;

    localparam int PtrBits = $clog2(QueueDepth);

    t_job               r_mem [QueueDepth];
    logic [PtrBits-1:0] r_wr, r_rd;
    logic [PtrBits:0]   r_cnt;

    assign o_full  = (r_cnt == (PtrBits+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* src/lpht_back.sv */
// Back part: probes each slot in a read and a check state and forms the result beat.
// Depends on lpht_pkg.
module lpht_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  lpht_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output lpht_pkg::t_out_beat o_beat
);
    import lpht_pkg::*;

    logic [1:0]           r_mark_mem  [TableDepth];
    logic [KeyBits-1:0]   r_key_mem   [TableDepth];
    logic [ValueBits-1:0] r_value_mem [TableDepth];

    t_back_state          r_state, n_state;
    t_job                 r_job;
    logic [SlotBits-1:0]  r_pos;
    logic [SlotBits:0]    r_seen;
    logic [1:0]           r_rd_mark;
    logic [KeyBits-1:0]   r_rd_key;
    logic [ValueBits-1:0] r_rd_value;
    logic [CountBits-1:0] r_live;
    logic                 r_valid;
    t_out_beat            r_beat;

    logic                 w_wr_mark;
    logic [1:0]           w_mark_data;
    logic                 w_wr_entry;
    logic                 w_finish;
    logic                 w_status;
    logic [31:0]          w_vout;
    logic [CountBits-1:0] w_live;
    logic                 w_hit;
    logic                 w_last;

    assign w_hit  = (r_rd_mark == MARK_LIVE) &&
                    (((r_rd_key ^ r_job.key_masked) & r_job.key_mask) == '0);
    assign w_last = (r_seen == (SlotBits+1)'(TableDepth - 1));

    always_ff @(posedge i_clk) begin
        if (w_wr_mark) begin
            r_mark_mem[r_pos] <= w_mark_data;
        end
        if (w_wr_entry) begin
            r_key_mem[r_pos]   <= r_job.key_masked;
            r_value_mem[r_pos] <= r_job.value;
        end
        r_rd_mark  <= r_mark_mem[r_pos];
        r_rd_key   <= r_key_mem[r_pos];
        r_rd_value <= r_value_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_pos   <= '0;
            r_live  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= w_live;
            if (w_finish) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (r_state == BS_CLEAR) begin
                r_pos <= r_pos + 1'b1;
            end else if (o_pop) begin
                r_pos <= i_job.home;
            end else if (r_state == BS_CHECK && n_state == BS_READ) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_seen <= '0;
        end else if (r_state == BS_CHECK) begin
            r_seen <= r_seen + 1'b1;
        end
        if (w_finish) begin
            r_beat.status    <= w_status;
            r_beat.value_out <= w_vout;
            r_beat.occupancy <= w_live;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_wr_mark   = 1'b0;
        w_mark_data = MARK_EMPTY;
        w_wr_entry  = 1'b0;
        w_finish    = 1'b0;
        w_status    = 1'b1;
        w_vout      = '0;
        w_live      = r_live;
        unique case (r_state)
            BS_CLEAR: begin
                w_wr_mark = 1'b1;
                if (r_pos == SlotBits'(TableDepth - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_empty && !(r_valid && i_stall)) begin
                    o_pop   = 1'b1;
                    n_state = (i_job.action == ACT_NONE) ? BS_DONE : BS_READ;
                end
            end
            BS_READ: begin
                n_state = BS_CHECK;
            end
            BS_CHECK: begin
                if (r_job.action == ACT_INSERT) begin
                    if (r_rd_mark != MARK_LIVE) begin
                        w_wr_mark   = 1'b1;
                        w_mark_data = MARK_LIVE;
                        w_wr_entry  = 1'b1;
                        w_live      = r_live + 1'b1;
                        w_status    = 1'b0;
                        w_finish    = 1'b1;
                        n_state     = BS_IDLE;
                    end else if (w_last) begin
                        w_finish = 1'b1;
                        n_state  = BS_IDLE;
                    end else begin
                        n_state = BS_READ;
                    end
                end else begin
                    if (r_rd_mark == MARK_EMPTY) begin
                        w_finish = 1'b1;
                        n_state  = BS_IDLE;
                    end else if (w_hit) begin
                        w_status = 1'b0;
                        w_finish = 1'b1;
                        n_state  = BS_IDLE;
                        if (r_job.action == ACT_GET) begin
                            w_vout = r_rd_value;
                        end else begin
                            w_wr_mark   = 1'b1;
                            w_mark_data = MARK_TOMB;
                            if (r_live != '0) begin
                                w_live = r_live - 1'b1;
                            end
                        end
                    end else if (w_last) begin
                        w_finish = 1'b1;
                        n_state  = BS_IDLE;
                    end else begin
                        n_state = BS_READ;
                    end
                end
            end
            BS_DONE: begin
                w_finish = 1'b1;
                n_state  = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* src/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: key width register, front, queue, back.
// Depends on lpht_pkg, lpht_front, lpht_queue and lpht_back.
//
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+----------------------------------
//   input    | in        | i_valid / o_stall    | t_in_beat: action, key, value
//   result   | out       | o_valid / i_stall    | t_out_beat: status, value_out, occupancy
//   config   | in        | i_cfg_we / i_cfg_data| key_bytes, 4 bits
//
// In the front, the FNV-1a hash runs one byte per cycle through a single 32x32
// multiply. The back takes the job, then visits each slot in a read state and a
// check state, set by the registered read of the slot memories; an unused action
// goes from taking the job straight to a done state.
// The front hashes the next beat while the back still probes the previous one.
// After reset the back clears the mark of every slot before it takes work; input
// beats are still hashed and queued in that time. A waiting result beat stops the
// back from starting a new item, but the front keeps accepting until the queue is full.
module linear_probe_hash_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lpht_pkg::t_in_beat  i_beat,
    output logic                o_valid,
    input  logic                i_stall,
    output lpht_pkg::t_out_beat o_beat,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data
);
    import lpht_pkg::*;

    // Key width register, applied when the front takes a beat.
    logic [3:0] r_key_bytes;

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_job       w_job_in;
    t_job       w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= 4'd4;
        end else if (i_cfg_we) begin
            r_key_bytes <= i_cfg_data;
        end
    end

    // The front takes beats and computes the home slot.
    lpht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_beat      (i_beat),
        .i_key_bytes (r_key_bytes),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .i_full      (w_full)
    );

    // The queue lets the front run ahead of the back.
    lpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    // The back walks the table and drives the result beat.
    lpht_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (o_beat)
    );

endmodule

/* bench/linear_probe_hash_table_tb.sv */
// Testbench for linear_probe_hash_table: directed table, then random insert/get/delete/none traffic.
// Depends on lpht_pkg and the RTL in src; every result beat is checked against a local table model.
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam int Depth = 256;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_beat;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_beat;
    logic      i_cfg_we;
    logic [3:0] i_cfg_data;

    linear_probe_hash_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_beat     (i_beat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_beat     (o_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // The model's copy of the table and the key width register.
    t_mark       mdl_mark [Depth];
    logic [63:0] mdl_key [Depth];
    logic [31:0] mdl_value [Depth];
    int unsigned mdl_live;
    logic [3:0]  mdl_key_bytes;

    // Results owed by the block, oldest first.
    t_out_beat   owed_results[$];
    int          fail_count;
    // When set, the receiver holds off for a long stretch so the block backs up.
    bit          hold_off_req;

    // Keys that were inserted, so gets and deletes mostly hit.
    logic [63:0] known_keys[$];

    typedef struct {
        t_action     act;
        logic [63:0] key;
        logic [31:0] value;
        bit          has_exp;
        t_out_beat   exp;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned width_bytes();
        int unsigned n;
        n = mdl_key_bytes;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    function automatic logic [63:0] width_mask(int unsigned n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic logic [7:0] home_slot(logic [63:0] key, int unsigned n);
        logic [31:0] h;
        h = FnvBasis;
        for (int i = 0; i < n; i++) begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * FnvMult;
        end
        return h[7:0];
    endfunction

    function automatic int find_live(logic [63:0] key, int unsigned n);
        logic [63:0] m;
        int          pos;
        m = width_mask(n);
        pos = int'(home_slot(key, n));
        for (int i = 0; i < Depth; i++) begin
            if (mdl_mark[pos] == MARK_EMPTY) return -1;
            if (mdl_mark[pos] == MARK_LIVE && ((mdl_key[pos] ^ key) & m) == 64'd0) return pos;
            pos = (pos + 1) % Depth;
        end
        return -1;
    endfunction

    // Applies one operation to the model table and returns the result beat it owes.
    function automatic t_out_beat apply_table_op(t_in_beat b);
        t_out_beat   r;
        int unsigned n;
        int          pos;
        int          hit;
        n = width_bytes();
        r = '0;
        r.status = 1'b1;
        case (t_action'(b.action))
            ACT_INSERT: begin
                pos = int'(home_slot(b.key, n));
                for (int i = 0; i < Depth; i++) begin
                    if (mdl_mark[pos] != MARK_LIVE) begin
                        mdl_mark[pos] = MARK_LIVE;
                        mdl_key[pos] = b.key & width_mask(n);
                        mdl_value[pos] = b.value;
                        mdl_live++;
                        r.status = 1'b0;
                        break;
                    end
                    pos = (pos + 1) % Depth;
                end
            end
            ACT_GET: begin
                hit = find_live(b.key, n);
                if (hit >= 0) begin
                    r.status = 1'b0;
                    r.value_out = mdl_value[hit];
                end
            end
            ACT_DELETE: begin
                hit = find_live(b.key, n);
                if (hit >= 0) begin
                    mdl_mark[hit] = MARK_TOMB;
                    if (mdl_live > 0) mdl_live--;
                    r.status = 1'b0;
                end
            end
            default: ;
        endcase
        r.occupancy = mdl_live[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Sends one beat, after a random gap, and records the result it owes.
    // The directed table may also give a typed-in expected result to compare.
    // Valid stays high after acceptance; it drops only when a gap follows or the bench waits to drain.
    task automatic send_beat(t_action act, logic [63:0] key, logic [31:0] value,
                             bit has_exp, t_out_beat exp, bit no_gap);
        t_in_beat  b;
        t_out_beat r;
        int        gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        b.action = act;
        b.key = key;
        b.value = value;
        i_valid <= 1'b1;
        i_beat <= b;
        // Wait for the accepting edge.
        do @(posedge i_clk); while (o_stall);
        r = apply_table_op(b);
        if (has_exp && r != exp)
            report_mismatch("directed row vs model", 64'(r), 64'(exp));
        owed_results.push_back(r);
        if (act == ACT_INSERT) known_keys.push_back(key);
    endtask

    // Writes the key width register; only called with nothing owed.
    task automatic write_key_width(logic [3:0] kb);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= kb;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_key_bytes = kb;
    endtask

    // Stops offering beats and waits until every owed result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall per beat, one long hold-off on request.
    initial begin
        int wait_cycles;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Checks every accepted result beat against the oldest owed one.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(o_beat), 64'd0);
            end else begin
                want = owed_results.pop_front();
                if (o_beat.status !== want.status)
                    report_mismatch("status", 64'(o_beat.status), 64'(want.status));
                if (o_beat.value_out !== want.value_out)
                    report_mismatch("value_out", 64'(o_beat.value_out), 64'(want.value_out));
                if (o_beat.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 64'(o_beat.occupancy),
                                    64'(want.occupancy));
            end
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Picks a key for random traffic: mostly known keys, some fresh, some near misses.
    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (known_keys.size() != 0 && sel < 6)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        if (known_keys.size() != 0 && sel < 8)
            return known_keys[$urandom_range(0, known_keys.size() - 1)]
                   ^ (64'd1 << $urandom_range(0, 63));
        return rand_key();
    endfunction

    task automatic random_phase(int count, int insert_weight);
        int       sel;
        t_action  act;
        t_out_beat none;
        none = '0;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < insert_weight) act = ACT_INSERT;
            else if (sel < insert_weight + (100 - insert_weight) / 2) act = ACT_GET;
            else if (sel < 98) act = ACT_DELETE;
            else act = ACT_NONE;
            send_beat(act, pick_key(), $urandom(), 1'b0, none, 1'b0);
        end
    endtask

    initial begin
        t_row      rows[$];
        t_row      row;
        t_out_beat ok0;
        t_out_beat miss0;
        t_out_beat none;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_beat = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = 4'd0;
        fail_count = 0;
        hold_off_req = 1'b0;
        for (int i = 0; i < Depth; i++) mdl_mark[i] = MARK_EMPTY;
        mdl_live = 0;
        mdl_key_bytes = 4'd4;
        none = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: after reset, extremes of the fields, every action.
        // A typed-in expectation stands where it is obvious; others use the model.
        miss0 = '0;
        miss0.status = 1'b1;
        ok0 = '0;
        row = '{ACT_GET, 64'd0, 32'd0, 1'b1, miss0};
        rows.push_back(row);
        row = '{ACT_DELETE, '1, 32'd0, 1'b1, miss0};
        rows.push_back(row);
        row = '{ACT_NONE, '1, '1, 1'b1, miss0};
        rows.push_back(row);
        ok0.occupancy = 9'd1;
        row = '{ACT_INSERT, 64'd0, '1, 1'b1, ok0};
        rows.push_back(row);
        ok0.value_out = '1;
        row = '{ACT_GET, 64'd0, 32'd0, 1'b1, ok0};
        rows.push_back(row);
        row = '{ACT_INSERT, '1, 32'd0, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_INSERT, 64'hA5A5_5A5A_0000_0000, 32'h1234_5678, 1'b0, none};
        rows.push_back(row);
        // Duplicate insert of key zero; upper bytes differ but are not compared.
        row = '{ACT_INSERT, 64'hFFFF_FFFF_0000_0000, 32'h0000_0001, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_GET, '1, 32'd0, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_DELETE, 64'd0, 32'd0, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_GET, 64'd0, 32'd0, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_DELETE, 64'd0, 32'd0, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_GET, 64'd0, 32'd0, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_INSERT, 64'h0123_4567_89AB_CDEF, 32'h8000_0000, 1'b0, none};
        rows.push_back(row);
        row = '{ACT_GET, 64'h0123_4567_89AB_CDEF, 32'd0, 1'b0, none};
        rows.push_back(row);
        foreach (rows[i])
            send_beat(rows[i].act, rows[i].key, rows[i].value, rows[i].has_exp,
                      rows[i].exp, 1'b0);
        wait_drained();

        // Random traffic at several key widths, the extremes and out-of-range codes too.
        random_phase(150, 40);
        wait_drained();
        write_key_width(4'd1);
        random_phase(120, 40);
        wait_drained();
        write_key_width(4'd8);
        // Long hold-off on the result side while the sender keeps offering beats.
        hold_off_req = 1'b1;
        random_phase(120, 40);
        wait_drained();
        write_key_width(4'd0);
        random_phase(60, 40);
        wait_drained();
        write_key_width(4'd15);
        random_phase(60, 40);
        wait_drained();
        write_key_width(4'd2);
        // Fill toward a full table with two-byte keys, then probe and delete.
        random_phase(300, 80);
        wait_drained();
        write_key_width(4'd4);
        random_phase(60, 30);

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
